>>> hdl/hlrv_pkg.sv
// Shared types and constants of the high-low range volatility estimator.
`timescale 1ns / 1ps
`default_nettype none

package hlrv_pkg;

    localparam int PRICE_W   = 32;
    localparam int E_W       = 5;
    localparam int LOG_FRAC  = 28;
    localparam int LOG_W     = E_W + LOG_FRAC;
    localparam int COEF_W    = 29;
    localparam int PROD_W    = LOG_W + COEF_W;
    localparam int PROD_FRAC = 58;
    localparam int VOL_W     = 20;
    localparam int OUT_FRAC  = 16;
    localparam int ROUND_SH  = PROD_FRAC - OUT_FRAC;
    localparam int CNT_W     = 5;

    // round(sqrt(ln 2) / 2 * 2^30)
    localparam logic [COEF_W-1:0] VOL_COEF = COEF_W'(446974353);

    typedef struct packed {
        logic [PRICE_W-1:0] high_price;
        logic [PRICE_W-1:0] low_price;
        logic               missing;
        logic               series_end;
    } in_beat_t;

    typedef struct packed {
        logic [VOL_W-1:0] volatility;
        logic             valid_res;
    } out_beat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc_en;
        logic norm_en;
        logic norm_sel;
        logic sq_en;
        logic save_h;
        logic sub_en;
        logic mul_en;
        logic out_load;
    } hlrv_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_valid;
        logic out_free;
    } hlrv_sts_t;

endpackage

`default_nettype wire

>>> hdl/hlrv_dp.sv
// Datapath: running extremes, shared log2 squaring unit, scaling and output register.
`timescale 1ns / 1ps
`default_nettype none

module hlrv_dp
    import hlrv_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire in_beat_t  s_data,
    input  wire hlrv_cmd_t cmd,
    output hlrv_sts_t      sts,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data
);

    logic [PRICE_W-1:0]   max_reg, min_reg, max_next, min_next;
    logic [PRICE_W-1:0]   h_op_reg, l_op_reg;
    logic                 op_valid_reg;
    logic [PRICE_W-1:0]   norm_x;
    logic [E_W-1:0]       norm_e;
    logic [PRICE_W-1:0]   m_reg;
    logic [E_W-1:0]       e_reg;
    logic [LOG_FRAC-1:0]  frac_reg;
    logic [2*PRICE_W-1:0] sq_prod;
    logic [PRICE_W:0]     sq_shift;
    logic [LOG_W-1:0]     log_h_reg, diff_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W:0]      rnd;
    logic [VOL_W:0]       vol_full;
    logic [VOL_W-1:0]     vol_sat;
    logic                 m_valid_reg;
    out_beat_t            m_data_reg;

    always_comb begin
        max_next = max_reg;
        min_next = min_reg;
        if (!s_data.missing) begin
            if (s_data.high_price > max_reg) begin
                max_next = s_data.high_price;
            end
            if (s_data.low_price < min_reg) begin
                min_next = s_data.low_price;
            end
        end
    end

    // Index of the top set bit of the selected operand.
    always_comb begin
        norm_x = cmd.norm_sel ? l_op_reg : h_op_reg;
        norm_e = '0;
        for (int i = 0; i < PRICE_W; i++) begin
            if (norm_x[i]) begin
                norm_e = E_W'(i);
            end
        end
    end

    assign sq_prod  = m_reg * m_reg;
    assign sq_shift = sq_prod[2*PRICE_W-1:PRICE_W-1];

    assign rnd      = {1'b0, prod_reg} + ((PROD_W+1)'(1) << (ROUND_SH - 1));
    assign vol_full = rnd[ROUND_SH+VOL_W:ROUND_SH];
    assign vol_sat  = vol_full[VOL_W] ? {VOL_W{1'b1}} : vol_full[VOL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg      <= '0;
            min_reg      <= '1;
            op_valid_reg <= 1'b0;
        end else if (cmd.acc_en) begin
            if (s_data.series_end) begin
                h_op_reg     <= max_next;
                l_op_reg     <= min_next;
                op_valid_reg <= (max_next != '0) && (min_next != '0) && (max_next > min_next);
                max_reg      <= '0;
                min_reg      <= '1;
            end else begin
                max_reg <= max_next;
                min_reg <= min_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.norm_en) begin
            m_reg    <= norm_x << (E_W'(PRICE_W - 1) - norm_e);
            e_reg    <= norm_e;
            frac_reg <= '0;
        end else if (cmd.sq_en) begin
            if (sq_shift[PRICE_W]) begin
                m_reg    <= sq_shift[PRICE_W:1];
                frac_reg <= {frac_reg[LOG_FRAC-2:0], 1'b1};
            end else begin
                m_reg    <= sq_shift[PRICE_W-1:0];
                frac_reg <= {frac_reg[LOG_FRAC-2:0], 1'b0};
            end
        end
        if (cmd.save_h) begin
            log_h_reg <= {e_reg, frac_reg};
        end
        if (cmd.sub_en) begin
            diff_reg <= log_h_reg - {e_reg, frac_reg};
        end
        if (cmd.mul_en) begin
            prod_reg <= diff_reg * VOL_COEF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.volatility <= op_valid_reg ? vol_sat : '0;
            m_data_reg.valid_res  <= op_valid_reg;
        end
    end

    assign sts.op_valid = op_valid_reg;
    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

endmodule

`default_nettype wire

>>> hdl/hlrv_ctrl.sv
// Controller: sequences accumulation, the two logarithms, scaling and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module hlrv_ctrl
    import hlrv_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      series_end,
    output logic           s_ready,
    input  wire hlrv_sts_t sts,
    output hlrv_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_NORM_H = 3'd1;
    localparam logic [2:0] S_SQ_H   = 3'd2;
    localparam logic [2:0] S_NORM_L = 3'd3;
    localparam logic [2:0] S_SQ_L   = 3'd4;
    localparam logic [2:0] S_SUB    = 3'd5;
    localparam logic [2:0] S_MUL    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             cnt_last;

    assign cnt_last = (cnt_reg == CNT_W'(LOG_FRAC - 1));

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.acc_en = s_valid;
                if (s_valid && series_end) begin
                    state_next = S_NORM_H;
                end
            end
            S_NORM_H: begin
                cnt_next = '0;
                if (sts.op_valid) begin
                    cmd.norm_en = 1'b1;
                    state_next  = S_SQ_H;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SQ_H: begin
                cmd.sq_en = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_last) begin
                    state_next = S_NORM_L;
                end
            end
            S_NORM_L: begin
                cmd.save_h   = 1'b1;
                cmd.norm_en  = 1'b1;
                cmd.norm_sel = 1'b1;
                cnt_next     = '0;
                state_next   = S_SQ_L;
            end
            S_SQ_L: begin
                cmd.sq_en = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_last) begin
                    state_next = S_SUB;
                end
            end
            S_SUB: begin
                cmd.sub_en = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/high_low_range_volatility.sv
// Top level of the Parkinson high-low range volatility estimator.
//
//   channel   direction  payload      purpose
//   s_        in         in_beat_t    one high/low price pair per beat
//   m_        out        out_beat_t   one volatility result per series
//
// A beat without series_end keeps the block idle: within a series a new beat
// is accepted every cycle. A series_end beat closes the series: the block then
// computes log2 of the maximum high and of the minimum low one after the other on
// a single shared 32x32 squaring multiplier, then subtracts, scales and rounds.
// s_ready stays low until the result is loaded, which waits while the previous
// result still sits in the output register; invalid series skip the arithmetic.
// aresetn is synchronous and active low; it clears the running extremes and
// drops m_valid. A stall on m_ready never blocks beats inside a series; it only
// lengthens the busy period after the next series_end beat.
`timescale 1ns / 1ps
`default_nettype none

module high_low_range_volatility
    import hlrv_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_beat_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_beat_t     m_data
);

    hlrv_cmd_t cmd;
    hlrv_sts_t sts;

    // The controller steps through the series-end computation; the datapath
    // holds all values and the output register.
    hlrv_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .series_end (s_data.series_end),
        .s_ready    (s_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    hlrv_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A series_end beat always starts the computation, so input stalls next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.series_end) |=> !s_ready)
        else $error("input accepted right after a series_end beat");

    // An invalid result always carries a zero volatility.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.valid_res) |-> (m_data.volatility == '0))
        else $error("invalid result with nonzero volatility");

    // A result is loaded only at the end of a computation, never while idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without a preceding computation");

    // The output is loaded only outside the idle state and only when it is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load) |-> (!s_ready && sts.out_free))
        else $error("output loaded while busy or full");

endmodule

`default_nettype wire

>>> dv/high_low_range_volatility_tb.sv
// Self-checking testbench of the high-low range volatility estimator.
`timescale 1ns / 1ps

module high_low_range_volatility_tb;
    import hlrv_pkg::*;

    // Arithmetic of the estimator, kept separate from the design's own constants.
    localparam int          LOG_Q          = 28;
    localparam int          VOL_SHIFT      = 42;    // Q.58 product down to Q.16
    localparam logic [63:0] SQRT_LN2_HALF  = 64'd446974353;
    localparam logic [63:0] VOL_CEILING    = 64'hFFFFF;

    // Run shape.
    localparam int RANDOM_BEATS   = 900;
    localparam int PAUSE_AT_BEAT  = 450;   // sender waits for all results here
    localparam int QUIET_AT_BEAT  = 800;   // from here on nobody idles
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES   = 100;
    localparam int MAX_PRINTS     = 40;

    typedef struct {
        in_beat_t  beat;
        bit        known;   // result typed in by hand
        out_beat_t want;
    } dir_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    // Running extremes of the series currently being collected.
    logic [PRICE_W-1:0] run_high = '0;
    logic [PRICE_W-1:0] run_low = '1;

    out_beat_t vol_expect_q[$];
    dir_row_t  dir_tab[$];

    int  mismatch_cnt = 0;
    int  beat_cnt = 0;
    int  series_cnt = 0;
    int  skipped_cnt = 0;
    int  invalid_cnt = 0;
    int  stall_cycles = 0;
    bit  no_idle = 1'b0;

    high_low_range_volatility u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 4 ns clock.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Every mismatch goes through here; printing is capped but counting is not.
    task automatic report_mismatch(input string what);
        if (mismatch_cnt < MAX_PRINTS) begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
        mismatch_cnt++;
    endtask

    // log2 of a nonzero price in Q.28: integer part from the top set bit, fraction
    // bits by repeated squaring of the Q1.31 mantissa with truncation.
    function automatic logic [32:0] log2_q28(input logic [PRICE_W-1:0] x);
        int          top;
        logic [63:0] mant;
        logic [27:0] frac;
        top = 0;
        frac = '0;
        for (int i = 0; i < PRICE_W; i++) begin
            if (x[i]) begin
                top = i;
            end
        end
        mant = 64'(x) << (31 - top);
        for (int i = 0; i < LOG_Q; i++) begin
            mant = (mant * mant) >> 31;
            frac = {frac[26:0], (mant >= 64'h1_0000_0000)};
            if (mant >= 64'h1_0000_0000) begin
                mant = mant >> 1;
            end
        end
        return {5'(top), frac};
    endfunction

    // Folds one accepted pair into the running extremes; on the last pair of a
    // series it yields the volatility and clears the extremes.
    task automatic predict_pair(input in_beat_t b, output bit emits, output out_beat_t res);
        logic [63:0] diff;
        logic [63:0] prod;
        logic [63:0] vol;
        emits = 1'b0;
        res = '0;
        if (!b.missing) begin
            if (b.high_price > run_high) begin
                run_high = b.high_price;
            end
            if (b.low_price < run_low) begin
                run_low = b.low_price;
            end
        end
        if (b.series_end) begin
            emits = 1'b1;
            // A zero extreme or a non-positive range gives an invalid result.
            if (run_high != 0 && run_low != 0 && run_high > run_low) begin
                diff = 64'(log2_q28(run_high)) - 64'(log2_q28(run_low));
                prod = diff * SQRT_LN2_HALF;
                vol = (prod + (64'd1 << (VOL_SHIFT - 1))) >> VOL_SHIFT;
                if (vol > VOL_CEILING) begin
                    vol = VOL_CEILING;
                end
                res.volatility = vol[VOL_W-1:0];
                res.valid_res = 1'b1;
            end
            run_high = '0;
            run_low = '1;
        end
    endtask

    // Holds s_valid low for the given number of cycles.
    task automatic sender_gap(input int cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // Drives one beat, waits for its handshake, then records what it should cause.
    // A hand-typed result, when given, replaces the predicted one.
    task automatic send_beat(input in_beat_t b, input bit known, input out_beat_t want);
        bit        emits;
        out_beat_t res;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            sender_gap($urandom_range(1, 19));
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge aclk); while (!s_ready);
        predict_pair(b, emits, res);
        beat_cnt++;
        if (b.missing) begin
            skipped_cnt++;
        end
        if (emits) begin
            vol_expect_q.push_back(known ? want : res);
        end
    endtask

    function automatic dir_row_t make_row(input logic [31:0] h, input logic [31:0] l,
                                          input bit miss, input bit last,
                                          input bit known, input logic [19:0] vol,
                                          input bit vres);
        dir_row_t r;
        r.beat.high_price = h;
        r.beat.low_price = l;
        r.beat.missing = miss;
        r.beat.series_end = last;
        r.known = known;
        r.want.volatility = vol;
        r.want.valid_res = vres;
        return r;
    endfunction

    // Random price of a random magnitude, never zero.
    function automatic logic [31:0] rand_price();
        logic [31:0] p;
        p = $urandom() >> $urandom_range(0, 31);
        return (p == 0) ? 32'd1 : p;
    endfunction

    // Result side: m_ready comes in random bursts of stall and accept, and stays
    // high once the quiet tail of the run has begun.
    initial begin : ready_driver
        int hold;
        bit lvl;
        hold = 0;
        lvl = 1'b1;
        forever begin
            @(negedge aclk);
            if (no_idle) begin
                m_ready <= 1'b1;
            end else begin
                if (hold == 0) begin
                    lvl = ($urandom_range(0, 2) != 0);
                    hold = $urandom_range(1, 19);
                end
                m_ready <= lvl;
                hold--;
            end
        end
    end

    // Result checker: each accepted result beat is matched against the oldest
    // expectation, field by field.
    always @(posedge aclk) begin
        out_beat_t exp_beat;
        if (aresetn && m_valid && m_ready) begin
            if (vol_expect_q.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected: vol=%0d valid=%0b",
                                          m_data.volatility, m_data.valid_res));
            end else begin
                exp_beat = vol_expect_q.pop_front();
                series_cnt++;
                if (!exp_beat.valid_res) begin
                    invalid_cnt++;
                end
                if (m_data.volatility !== exp_beat.volatility) begin
                    report_mismatch($sformatf("volatility got %0d, expected %0d",
                                              m_data.volatility, exp_beat.volatility));
                end
                if (m_data.valid_res !== exp_beat.valid_res) begin
                    report_mismatch($sformatf("valid_res got %0b, expected %0b",
                                              m_data.valid_res, exp_beat.valid_res));
                end
            end
        end
    end

    // Watchdog: a run in which no beat moves on either channel for too long has hung.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired after %0d idle cycles, %0d results outstanding",
                         stall_cycles, vol_expect_q.size());
                $display("high_low_range_volatility regression: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        in_beat_t b;
        int       len;
        bit       noise;
        bit       paused;
        paused = 1'b0;

        // Directed table. Invalid cases and the exact power-of-two ratio are typed
        // in; everything else comes from the predictor.
        dir_tab.push_back(make_row(32'h0, 32'h0, 0, 1, 1, 20'd0, 0));       // both zero
        dir_tab.push_back(make_row(32'hFFFFFFFF, 32'h1, 1, 1, 1, 20'd0, 0)); // empty series
        dir_tab.push_back(make_row(32'd100, 32'd100, 0, 1, 1, 20'd0, 0));    // high equals low
        dir_tab.push_back(make_row(32'd50, 32'd100, 0, 1, 1, 20'd0, 0));     // high below low
        dir_tab.push_back(make_row(32'd5, 32'd0, 0, 1, 1, 20'd0, 0));        // low is zero
        dir_tab.push_back(make_row(32'd0, 32'd7, 0, 1, 1, 20'd0, 0));        // high is zero
        dir_tab.push_back(make_row(32'd2, 32'd1, 0, 1, 1, 20'd27281, 1));    // one octave
        dir_tab.push_back(make_row(32'hFFFFFFFF, 32'h1, 0, 1, 0, '0, 0));    // widest range
        dir_tab.push_back(make_row(32'hFFFFFFFF, 32'hFFFFFFFE, 0, 1, 0, '0, 0));
        dir_tab.push_back(make_row(32'h80000000, 32'h1, 0, 1, 0, '0, 0));
        dir_tab.push_back(make_row(32'd3, 32'd2, 0, 1, 0, '0, 0));
        // A longer series with a skipped pair that would otherwise dominate.
        dir_tab.push_back(make_row(32'd1000, 32'd900, 0, 0, 0, '0, 0));
        dir_tab.push_back(make_row(32'd1200, 32'd950, 0, 0, 0, '0, 0));
        dir_tab.push_back(make_row(32'hFFFFFFFF, 32'h0, 1, 0, 0, '0, 0));
        dir_tab.push_back(make_row(32'd1100, 32'd800, 0, 1, 0, '0, 0));
        // The closing pair itself is missing: the result uses the earlier pair only.
        dir_tab.push_back(make_row(32'd300, 32'd200, 0, 0, 0, '0, 0));
        dir_tab.push_back(make_row(32'hFFFFFFFF, 32'h1, 1, 1, 0, '0, 0));
        // Extremes picked up from different pairs; a zero low spoils the series.
        dir_tab.push_back(make_row(32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, '0, 0));
        dir_tab.push_back(make_row(32'h0, 32'h0, 0, 1, 1, 20'd0, 0));
        // The state must be fresh again after an invalid series.
        dir_tab.push_back(make_row(32'hAAAAAAAA, 32'h55555555, 0, 1, 0, '0, 0));

        // Reset once, at the start of the run.
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            send_beat(dir_tab[i].beat, dir_tab[i].known, dir_tab[i].want);
        end

        // Random part: mostly well-formed series of random length with a low below
        // the high, some noise series of raw values, zeros and missing pairs.
        while (beat_cnt < RANDOM_BEATS + dir_tab.size()) begin
            if (!paused && beat_cnt >= PAUSE_AT_BEAT) begin
                // Let the block drain completely before going on.
                paused = 1'b1;
                @(negedge aclk);
                s_valid <= 1'b0;
                while (vol_expect_q.size() != 0) @(posedge aclk);
            end
            if (beat_cnt >= QUIET_AT_BEAT) begin
                no_idle = 1'b1;
            end
            noise = ($urandom_range(0, 9) == 0);
            len = noise ? $urandom_range(1, 4) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                if (noise) begin
                    b.high_price = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom();
                    b.low_price = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom();
                    b.missing = ($urandom_range(0, 2) == 0);
                end else begin
                    b.high_price = rand_price();
                    b.low_price = (b.high_price > 1) ? $urandom_range(1, b.high_price - 1)
                                                     : 32'd1;
                    b.missing = ($urandom_range(0, 7) == 0);
                end
                b.series_end = (k == len - 1);
                send_beat(b, 1'b0, '0);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (vol_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d beats (%0d skipped as missing) closing %0d series,",
                 beat_cnt, skipped_cnt, series_cnt);
        $display("%0d of them invalid, with random stalls on both channels and a full drain",
                 invalid_cnt);
        if (mismatch_cnt == 0) begin
            $display("high_low_range_volatility regression: pass");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("high_low_range_volatility regression: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/hlrv_pkg.sv
hdl/hlrv_dp.sv
hdl/hlrv_ctrl.sv
hdl/high_low_range_volatility.sv
dv/high_low_range_volatility_tb.sv
